/* hw/rtl/pspm_pkg.sv */
`default_nettype none

package pspm_pkg;

   localparam int SAMPLE_W = 10;
   localparam int BYTE_W   = 8;

   localparam logic [BYTE_W-1:0]   STATUS_NORMAL    = 8'h01;
   localparam logic [BYTE_W-1:0]   STATUS_ERROR     = 8'hFF;
   localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET  = 10'd100;

   // accept, group-end and per-stage enables shared by both sensor lanes
   typedef struct packed {
      logic accept;
      logic group_end;
      logic en1;
      logic en2;
      logic en3;
   } lane_ctl_type;

   typedef struct packed {
      logic [BYTE_W-1:0]   status_byte;
      logic [BYTE_W-1:0]   accel_byte;
      logic [SAMPLE_W-1:0] fault_raw_one;
      logic [SAMPLE_W-1:0] fault_raw_two;
      logic                plausible;
   } frame_type;

endpackage

`default_nettype wire

/* hw/rtl/pedal_sensor_plausibility_monitor.sv */
`default_nettype none

// Pedal sensor plausibility monitor. Takes one pair of 10-bit readings per
// cycle while rsp_tready does not stall it, and keeps a running sum per sensor;
// every SAMPLES_PER_CHECK pairs it checks the difference of the two averages
// against the threshold (csr_data, 100 after reset) and sends one frame (status
// 0x01 with a fresh accel byte, or 0xFF once the sensors disagree). The error is
// sticky until reset, and from then on every request yields an error frame.
// Otherwise requests that do not close a group yield nothing. Throughput is one
// request per cycle while the output is not stalled; each frame passes through
// the lane pipeline (accumulate, divide by reciprocal multiply, scale) and the
// merge/output register. Write csr_data only while no request is in flight.
module pedal_sensor_plausibility_monitor
   import pspm_pkg::*;
#(
   parameter int SAMPLES_PER_CHECK = 10,
   parameter int GAIN_DIVISOR      = 200
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // sample_one[9:0], sample_two[19:10], zero pad
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [39:0] rsp_tdata,   // status_byte[7:0], accel_byte[15:8],
                                         // fault_raw_one[25:16], fault_raw_two[35:26],
                                         // plausible[36], zero pad
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [9:0]  csr_data
);

   localparam int CNT_W = $clog2(SAMPLES_PER_CHECK + 1);

   logic [SAMPLE_W-1:0] thr_ff;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                accept, group_end;
   logic                v1_ff, v2_ff, v3_ff;
   logic                e1_ff, e2_ff, e3_ff;
   logic                rdy1, rdy2, rdy3, rdy_out;
   lane_ctl_type        ctl;
   logic [SAMPLE_W-1:0] avg_one, avg_two;
   logic [BYTE_W-1:0]   scaled_one, scaled_two;
   frame_type           frame;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THRESHOLD_RESET;
      end else if (csr_valid) begin
         thr_ff <= csr_data;
      end
   end

   // stage ready chain: a stage loads whenever it is empty or its successor moves
   assign rdy3       = !v3_ff || rdy_out;
   assign rdy2       = !v2_ff || rdy3;
   assign rdy1       = !v1_ff || rdy2;
   assign req_tready = rdy1;
   assign accept     = req_tvalid && rdy1;
   assign group_end  = (cnt_ff == CNT_W'(SAMPLES_PER_CHECK - 1));
   assign cnt_in     = group_end ? '0 : cnt_ff + CNT_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         v3_ff  <= 1'b0;
      end else begin
         if (accept) begin
            cnt_ff <= cnt_in;
         end
         if (rdy1) begin
            v1_ff <= accept;
         end
         if (rdy2) begin
            v2_ff <= v1_ff;
         end
         if (rdy3) begin
            v3_ff <= v2_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         e1_ff <= group_end;
      end
      if (rdy2) begin
         e2_ff <= e1_ff;
      end
      if (rdy3) begin
         e3_ff <= e2_ff;
      end
   end

   assign ctl.accept    = accept;
   assign ctl.group_end = group_end;
   assign ctl.en1       = rdy1;
   assign ctl.en2       = rdy2;
   assign ctl.en3       = rdy3;

   pspm_lane #(
      .SAMPLES_PER_CHECK (SAMPLES_PER_CHECK),
      .GAIN_DIVISOR      (GAIN_DIVISOR)
   ) u_lane_one (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl),
      .sample (req_tdata[9:0]),
      .avg    (avg_one),
      .scaled (scaled_one)
   );

   pspm_lane #(
      .SAMPLES_PER_CHECK (SAMPLES_PER_CHECK),
      .GAIN_DIVISOR      (GAIN_DIVISOR)
   ) u_lane_two (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl),
      .sample (req_tdata[19:10]),
      .avg    (avg_two),
      .scaled (scaled_two)
   );

   pspm_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .threshold  (thr_ff),
      .item_valid (v3_ff),
      .item_end   (e3_ff),
      .avg_one    (avg_one),
      .avg_two    (avg_two),
      .scaled_one (scaled_one),
      .scaled_two (scaled_two),
      .item_ready (rdy_out),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .frame      (frame)
   );

   assign rsp_tdata = {3'b000, frame.plausible, frame.fault_raw_two, frame.fault_raw_one,
                       frame.accel_byte, frame.status_byte};

endmodule

`default_nettype wire

/* hw/rtl/pspm_lane.sv */
`default_nettype none

module pspm_lane
   import pspm_pkg::*;
#(
   parameter int SAMPLES_PER_CHECK = 10,
   parameter int GAIN_DIVISOR      = 200
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire lane_ctl_type        ctl,
   input  wire logic [SAMPLE_W-1:0] sample,
   output logic      [SAMPLE_W-1:0] avg,
   output logic      [BYTE_W-1:0]   scaled
);

   localparam int SUM_MAX = SAMPLES_PER_CHECK * 1023;
   localparam int SUM_W   = $clog2(SUM_MAX + 1);

   // sum / SAMPLES_PER_CHECK by reciprocal multiply, exact for SUM_W-bit sums
   localparam int A_L  = $clog2(SAMPLES_PER_CHECK);
   localparam int A_K  = SUM_W + A_L;
   localparam longint unsigned A_M =
      ((64'd1 << A_K) + 64'(SAMPLES_PER_CHECK) - 64'd1) / 64'(SAMPLES_PER_CHECK);
   localparam int A_MW = $clog2(A_M + 64'd1);
   localparam int A_PW = (SUM_W + A_MW > A_K + SAMPLE_W) ? SUM_W + A_MW : A_K + SAMPLE_W;

   // sum / GAIN_DIVISOR
   localparam int QW   = $clog2(SUM_MAX / GAIN_DIVISOR + 1);
   localparam int G_L  = $clog2(GAIN_DIVISOR);
   localparam int G_K  = SUM_W + G_L;
   localparam longint unsigned G_M =
      ((64'd1 << G_K) + 64'(GAIN_DIVISOR) - 64'd1) / 64'(GAIN_DIVISOR);
   localparam int G_MW = $clog2(G_M + 64'd1);
   localparam int G_PW = (SUM_W + G_MW > G_K + QW) ? SUM_W + G_MW : G_K + QW;

   // (q * 255) / 1023
   localparam int TW   = QW + 8;
   localparam int S_K  = TW + 10;
   localparam longint unsigned S_M = ((64'd1 << S_K) + 64'd1022) / 64'd1023;
   localparam int S_MW = $clog2(S_M + 64'd1);
   localparam int S_PW = (TW + S_MW > S_K + BYTE_W) ? TW + S_MW : S_K + BYTE_W;

   logic [SUM_W-1:0]    acc_ff, acc_in;
   logic [SUM_W-1:0]    total;
   logic [SUM_W-1:0]    total_ff;
   logic [A_PW-1:0]     avg_prod;
   logic [G_PW-1:0]     gain_prod;
   logic [SAMPLE_W-1:0] avg2_ff, avg3_ff;
   logic [QW-1:0]       q_ff;
   logic [TW-1:0]       q_x255;
   logic [S_PW-1:0]     scale_prod;
   logic [BYTE_W-1:0]   scaled_ff;

   assign total  = acc_ff + SUM_W'(sample);
   assign acc_in = ctl.group_end ? '0 : total;

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else if (ctl.accept) begin
         acc_ff <= acc_in;
      end
   end

   assign avg_prod  = A_PW'(total_ff) * A_PW'(A_M);
   assign gain_prod = G_PW'(total_ff) * G_PW'(G_M);
   assign q_x255    = {q_ff, 8'b0} - TW'(q_ff);
   assign scale_prod = S_PW'(q_x255) * S_PW'(S_M);

   always_ff @(posedge clock) begin
      if (ctl.en1) begin
         total_ff <= total;
      end
      if (ctl.en2) begin
         avg2_ff <= avg_prod[A_K +: SAMPLE_W];
         q_ff    <= gain_prod[G_K +: QW];
      end
      if (ctl.en3) begin
         avg3_ff   <= avg2_ff;
         scaled_ff <= scale_prod[S_K +: BYTE_W];
      end
   end

   assign avg    = avg3_ff;
   assign scaled = scaled_ff;

endmodule

`default_nettype wire

/* hw/rtl/pspm_merge.sv */
`default_nettype none

module pspm_merge
   import pspm_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic [SAMPLE_W-1:0] threshold,
   input  wire logic                item_valid,
   input  wire logic                item_end,
   input  wire logic [SAMPLE_W-1:0] avg_one,
   input  wire logic [SAMPLE_W-1:0] avg_two,
   input  wire logic [BYTE_W-1:0]   scaled_one,
   input  wire logic [BYTE_W-1:0]   scaled_two,
   output logic                     item_ready,
   output logic                     out_valid,
   input  wire logic                out_ready,
   output frame_type                frame
);

   logic                err_ff, err_in;
   logic [BYTE_W-1:0]   accel_ff, accel_in;
   logic [SAMPLE_W-1:0] fault_one_ff, fault_one_in;
   logic [SAMPLE_W-1:0] fault_two_ff, fault_two_in;
   logic                out_valid_ff, out_valid_in;
   frame_type           frame_ff, frame_in;
   logic [SAMPLE_W-1:0] diff;
   logic                consume;
   logic                has_result;
   logic [BYTE_W:0]     scaled_sum;

   assign item_ready = !out_valid_ff || out_ready;
   assign consume    = item_valid && item_ready;
   assign diff       = (avg_one >= avg_two) ? avg_one - avg_two : avg_two - avg_one;
   assign scaled_sum = {1'b0, scaled_one} + {1'b0, scaled_two};

   always_comb begin
      err_in       = err_ff;
      accel_in     = accel_ff;
      fault_one_in = fault_one_ff;
      fault_two_in = fault_two_ff;
      has_result   = 1'b0;
      frame_in.status_byte = STATUS_ERROR;
      if (consume) begin
         if (err_ff) begin
            has_result = 1'b1;
         end else if (item_end) begin
            has_result = 1'b1;
            if (diff >= threshold) begin
               err_in       = 1'b1;
               fault_one_in = avg_one;
               fault_two_in = avg_two;
            end else begin
               accel_in             = scaled_sum[BYTE_W:1];
               frame_in.status_byte = STATUS_NORMAL;
            end
         end
      end
      frame_in.accel_byte    = accel_in;
      frame_in.fault_raw_one = fault_one_in;
      frame_in.fault_raw_two = fault_two_in;
      frame_in.plausible     = (frame_in.status_byte == STATUS_NORMAL);
      out_valid_in = item_ready ? has_result : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         err_ff       <= 1'b0;
         accel_ff     <= '0;
         fault_one_ff <= '0;
         fault_two_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         err_ff       <= err_in;
         accel_ff     <= accel_in;
         fault_one_ff <= fault_one_in;
         fault_two_ff <= fault_two_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (has_result) begin
         frame_ff <= frame_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign frame     = frame_ff;

`ifndef ASSERT_OFF
   a_err_sticky: assert property (@(posedge clock) disable iff (reset)
      err_ff |=> err_ff)
      else $error("error latch cleared without reset");

   a_fault_zero: assert property (@(posedge clock) disable iff (reset)
      !err_ff |-> (fault_one_ff == '0 && fault_two_ff == '0))
      else $error("fault averages recorded without an error");

   a_err_frame: assert property (@(posedge clock) disable iff (reset)
      (err_ff && consume) |=> (out_valid_ff && !frame_ff.plausible
                               && frame_ff.status_byte == STATUS_ERROR))
      else $error("latched error did not yield an error frame");

   a_plausible: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (frame_ff.plausible == (frame_ff.status_byte == STATUS_NORMAL)))
      else $error("plausible flag disagrees with status byte");
`endif

endmodule

`default_nettype wire
